@@ src/grm_pkg.sv @@
// Shared constants, widths and types for the grid ray marcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package grm_pkg;

  // Map geometry and store
  localparam int GRID_WIDTH  = 32;
  localparam int GRID_HEIGHT = 32;
  localparam int MAP_CELLS   = 1024;
  localparam int MAP_AW      = 10;

  // Field widths
  localparam int STEP_W  = 10;
  localparam int LIMIT_W = 15;
  localparam int POS_W   = 15;
  localparam int DIR_W   = 16;
  localparam int DIST_W  = 16;
  localparam int WALL_W  = 5;

  // Sample point: Q.24, signed, wide enough for origin plus any dir * dist
  localparam int FRAC_SHIFT = 24;
  localparam int SAMPLE_W   = 33;
  localparam int TILE_W     = SAMPLE_W - FRAC_SHIFT;

  // Face offset (tile edge minus origin) in Q.10, and the shared multiplier
  localparam int EX_W   = TILE_W + 12;
  localparam int MUL_W  = EX_W;
  localparam int PROD_W = 2 * MUL_W;

  // Linear tile address, wide enough to tell addresses beyond the store
  localparam int GRID_AW = $clog2(GRID_WIDTH * GRID_HEIGHT);
  localparam int ADDR_W  = (GRID_AW > MAP_AW) ? GRID_AW : MAP_AW + 1;

  // Register reset values
  localparam logic [STEP_W-1:0]  STEP_RESET  = 10'd102;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd20480;

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  // Register indexes (paddr[2])
  localparam logic REG_STEP  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic              outside;
    logic [TILE_W-1:0] tile;
  } tile_info_t;

endpackage

@@ src/grm_tile_conv.sv @@
// Truncates one Q.24 sample coordinate toward zero to a tile number and
// flags it when it lies off the map. Depends on grm_pkg.
`timescale 1ns / 1ps

module grm_tile_conv import grm_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic        [TILE_W-1:0]   extent_i,
  output tile_info_t                 info_o
);

  logic                neg;
  logic [SAMPLE_W-1:0] mag;
  logic [TILE_W-1:0]   whole;

  // Take the magnitude, drop the fraction
  assign neg   = sample_i[SAMPLE_W-1];
  assign mag   = neg ? SAMPLE_W'(-sample_i) : SAMPLE_W'(sample_i);
  assign whole = mag[SAMPLE_W-1:FRAC_SHIFT];

  // A negative sample above -1 still lands on tile 0
  always_comb begin
    info_o.outside = neg ? (whole != '0) : (whole >= extent_i);
    info_o.tile    = neg ? '0 : whole;
  end

endmodule

@@ src/grid_ray_marcher_unit.sv @@
// Grid ray marcher top level: APB registers, wall map, march sequencer
// and the shared multiplier. Depends on grm_pkg and grm_tile_conv.
//
//   channel   signals                          direction  beat
//   in        in_valid_i / in_ready_o + fields  to block   load or cast
//   out       out_valid_o / out_ready_i+fields  from block one per cast
//   cfg       psel penable pwrite paddr pwdata  to block   register write
//
// After reset the wall map is cleared one cell a cycle with in_ready_o
// low (register writes are taken). A load writes the map when accepted.
// A cast runs each march step through STEP, MULX, MULZ, CHECK and LOOK
// (two passes through the shared multiplier, tile check, map read) between
// accept in IDLE and hand-off in DONE; a map edge ends the last step in
// CHECK, a miss takes one more STEP, a wall hit SIDEX, SIDEZ, SIDEC for the
// face side. The result sits in an output register; the next beat is taken
// while it waits, and a cast stalls in DONE only if the previous result is untaken.
`timescale 1ns / 1ps

module grid_ray_marcher_unit import grm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [MAP_AW-1:0]         map_index_i,
  input  logic                      map_solid_i,
  input  logic [POS_W-1:0]          origin_x_i,
  input  logic [POS_W-1:0]          origin_z_i,
  input  logic signed [DIR_W-1:0]   dir_x_i,
  input  logic signed [DIR_W-1:0]   dir_z_i,
  // results
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic [DIST_W-1:0]         distance_o,
  output logic [WALL_W-1:0]         wall_x_o,
  output logic [WALL_W-1:0]         wall_z_o,
  output logic                      side_o
);

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_STEP  = 4'd2;
  localparam logic [3:0] S_MULX  = 4'd3;
  localparam logic [3:0] S_MULZ  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_LOOK  = 4'd6;
  localparam logic [3:0] S_SIDEX = 4'd7;
  localparam logic [3:0] S_SIDEZ = 4'd8;
  localparam logic [3:0] S_SIDEC = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]               state_q, state_d;
  logic [MAP_AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [STEP_W-1:0]        step_len_q;
  logic [LIMIT_W-1:0]       dist_limit_q;

  // Per-cast operands and march state
  logic [POS_W-1:0]         ox_q, ox_d, oz_q, oz_d;
  logic signed [DIR_W-1:0]  dx_q, dx_d, dz_q, dz_d;
  logic [DIR_W:0]           abs_dx_q, abs_dx_d, abs_dz_q, abs_dz_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [DIST_W-1:0]        dist_q, dist_d;
  logic signed [SAMPLE_W-1:0] px_q, px_d;
  logic [TILE_W-1:0]        tile_x_q, tile_x_d, tile_z_q, tile_z_d;
  logic                     addr_ok_q, addr_ok_d;
  logic [EX_W-2:0]          abs_ex_q, abs_ex_d, abs_ez_q, abs_ez_d;
  logic [PROD_W-2:0]        lhs_q, lhs_d;

  // Pending result
  logic                     res_hit_q, res_hit_d;
  logic [DIST_W-1:0]        res_dist_q, res_dist_d;
  logic [WALL_W-1:0]        res_wx_q, res_wx_d, res_wz_q, res_wz_d;
  logic                     res_side_q, res_side_d;

  // Output register
  logic                     out_valid_q, out_valid_d;
  logic                     out_hit_q;
  logic [DIST_W-1:0]        out_dist_q;
  logic [WALL_W-1:0]        out_wx_q, out_wz_q;
  logic                     out_side_q;
  logic                     out_load;

  // Shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;

  // Wall map
  logic                     mem_q [MAP_CELLS];
  logic                     rd_q;
  logic                     mem_we, mem_wdata, mem_re;
  logic [MAP_AW-1:0]        mem_waddr, mem_raddr;

  // Tile check datapath
  logic signed [SAMPLE_W-1:0] pz;
  tile_info_t               info_x, info_z;
  logic [ADDR_W-1:0]        addr_full;
  logic                     in_store;
  logic                     dx_pos, dz_pos;
  logic signed [EX_W-1:0]   ex, ez;
  logic                     cfg_wr, in_beat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat = in_valid_i & in_ready_o;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_len_q   <= STEP_RESET;
      dist_limit_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_STEP:  step_len_q   <= pwdata[STEP_W-1:0];
        REG_LIMIT: dist_limit_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STEP:  prdata = 32'(step_len_q);
      REG_LIMIT: prdata = 32'(dist_limit_q);
      default:   prdata = '0;
    endcase
  end

  // Sample z from the product now in the multiplier register
  assign pz = $signed({{(SAMPLE_W-POS_W-14){1'b0}}, oz_q, 14'b0}) + prod_q[SAMPLE_W-1:0];

  grm_tile_conv u_conv_x (
    .sample_i (px_q),
    .extent_i (TILE_W'(GRID_WIDTH)),
    .info_o   (info_x)
  );

  grm_tile_conv u_conv_z (
    .sample_i (pz),
    .extent_i (TILE_W'(GRID_HEIGHT)),
    .info_o   (info_z)
  );

  assign addr_full = ADDR_W'(info_z.tile) * ADDR_W'(GRID_WIDTH) + ADDR_W'(info_x.tile);
  assign in_store  = addr_full < ADDR_W'(MAP_CELLS);
  assign mem_raddr = addr_full[MAP_AW-1:0];

  // Face offsets: edge of the hit tile on the far side along the ray, less origin
  assign dx_pos = !dx_q[DIR_W-1] && (dx_q != '0);
  assign dz_pos = !dz_q[DIR_W-1] && (dz_q != '0);
  assign ex = $signed({1'b0, {1'b0, tile_x_q} + (TILE_W+1)'(dx_pos), 10'b0})
            - $signed({{(EX_W-POS_W){1'b0}}, ox_q});
  assign ez = $signed({1'b0, {1'b0, tile_z_q} + (TILE_W+1)'(dz_pos), 10'b0})
            - $signed({{(EX_W-POS_W){1'b0}}, oz_q});

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer and datapath next values
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    ox_d       = ox_q;
    oz_d       = oz_q;
    dx_d       = dx_q;
    dz_d       = dz_q;
    abs_dx_d   = abs_dx_q;
    abs_dz_d   = abs_dz_q;
    step_d     = step_q;
    dist_d     = dist_q;
    px_d       = px_q;
    tile_x_d   = tile_x_q;
    tile_z_d   = tile_z_q;
    addr_ok_d  = addr_ok_q;
    abs_ex_d   = abs_ex_q;
    abs_ez_d   = abs_ez_q;
    lhs_d      = lhs_q;
    res_hit_d  = res_hit_q;
    res_dist_d = res_dist_q;
    res_wx_d   = res_wx_q;
    res_wz_d   = res_wz_q;
    res_side_d = res_side_q;
    mul_a      = '0;
    mul_b      = '0;
    mem_we     = 1'b0;
    mem_waddr  = map_index_i;
    mem_wdata  = map_solid_i;
    mem_re     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // sweep the map clear after reset
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 1'b0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == MAP_AW'(MAP_CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          if (opcode_i == OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            ox_d     = origin_x_i;
            oz_d     = origin_z_i;
            dx_d     = dir_x_i;
            dz_d     = dir_z_i;
            abs_dx_d = dir_x_i[DIR_W-1] ? (DIR_W+1)'(-{dir_x_i[DIR_W-1], dir_x_i})
                                        : (DIR_W+1)'(dir_x_i);
            abs_dz_d = dir_z_i[DIR_W-1] ? (DIR_W+1)'(-{dir_z_i[DIR_W-1], dir_z_i})
                                        : (DIR_W+1)'(dir_z_i);
            step_d   = (step_len_q == '0) ? STEP_W'(1) : step_len_q;
            dist_d   = '0;
            state_d  = S_STEP;
          end
        end
      end
      S_STEP: begin
        // stop at the limit with a miss, else advance the distance
        if (dist_q >= DIST_W'(dist_limit_q)) begin
          res_hit_d  = 1'b0;
          res_dist_d = '0;
          res_wx_d   = '0;
          res_wz_d   = '0;
          res_side_d = 1'b0;
          state_d    = S_DONE;
        end else begin
          dist_d  = dist_q + DIST_W'(step_q);
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        mul_a   = MUL_W'(dx_q);
        mul_b   = $signed(MUL_W'(dist_q));
        state_d = S_MULZ;
      end
      S_MULZ: begin
        px_d    = $signed({{(SAMPLE_W-POS_W-14){1'b0}}, ox_q, 14'b0}) + prod_q[SAMPLE_W-1:0];
        mul_a   = MUL_W'(dz_q);
        mul_b   = $signed(MUL_W'(dist_q));
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // off the map ends the march; else read the tile
        if (info_x.outside || info_z.outside) begin
          res_hit_d  = 1'b1;
          res_dist_d = dist_q;
          res_wx_d   = '0;
          res_wz_d   = '0;
          res_side_d = 1'b0;
          state_d    = S_DONE;
        end else begin
          mem_re    = 1'b1;
          tile_x_d  = info_x.tile;
          tile_z_d  = info_z.tile;
          addr_ok_d = in_store;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        abs_ex_d = ex[EX_W-1] ? (EX_W-1)'(-ex) : (EX_W-1)'(ex);
        abs_ez_d = ez[EX_W-1] ? (EX_W-1)'(-ez) : (EX_W-1)'(ez);
        state_d  = (rd_q && addr_ok_q) ? S_SIDEX : S_STEP;
      end
      S_SIDEX: begin
        mul_a   = $signed(MUL_W'(abs_ex_q));
        mul_b   = $signed(MUL_W'(abs_dz_q));
        state_d = S_SIDEZ;
      end
      S_SIDEZ: begin
        lhs_d   = prod_q[PROD_W-2:0];
        mul_a   = $signed(MUL_W'(abs_ez_q));
        mul_b   = $signed(MUL_W'(abs_dx_q));
        state_d = S_SIDEC;
      end
      S_SIDEC: begin
        // vertical face nearer along the ray gives side 0
        res_hit_d  = 1'b1;
        res_dist_d = dist_q;
        res_wx_d   = tile_x_q[WALL_W-1:0];
        res_wz_d   = tile_z_q[WALL_W-1:0];
        res_side_d = (lhs_q < prod_q[PROD_W-2:0]) ? 1'b0 : 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold a result until the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ox_q       <= ox_d;
    oz_q       <= oz_d;
    dx_q       <= dx_d;
    dz_q       <= dz_d;
    abs_dx_q   <= abs_dx_d;
    abs_dz_q   <= abs_dz_d;
    step_q     <= step_d;
    dist_q     <= dist_d;
    px_q       <= px_d;
    tile_x_q   <= tile_x_d;
    tile_z_q   <= tile_z_d;
    addr_ok_q  <= addr_ok_d;
    abs_ex_q   <= abs_ex_d;
    abs_ez_q   <= abs_ez_d;
    lhs_q      <= lhs_d;
    res_hit_q  <= res_hit_d;
    res_dist_q <= res_dist_d;
    res_wx_q   <= res_wx_d;
    res_wz_q   <= res_wz_d;
    res_side_q <= res_side_d;
    prod_q     <= mul_a * mul_b;
    if (out_load) begin
      out_hit_q  <= res_hit_q;
      out_dist_q <= res_dist_q;
      out_wx_q   <= res_wx_q;
      out_wz_q   <= res_wz_q;
      out_side_q <= res_side_q;
    end
  end

  // Wall map: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign distance_o  = out_dist_q;
  assign wall_x_o    = out_wx_q;
  assign wall_z_o    = out_wz_q;
  assign side_o      = out_side_q;

endmodule
